>>> sv/robot_kinematic_pose_update_top_macros.svh
// Assertion macros for the pose update block.
// Used by robot_kinematic_pose_update_top; needs nothing else.
`ifndef ROBOT_KINEMATIC_POSE_UPDATE_TOP_MACROS_SVH
`define ROBOT_KINEMATIC_POSE_UPDATE_TOP_MACROS_SVH

// Flag a condition that must never hold outside reset.
`define RKPU_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("pose update: forbidden condition");

// Flag a consequent that fails in the cycle after its trigger.
`define RKPU_ASSERT_NEXT(lbl, clk, rst_n, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("pose update: sequence broken");

`endif

>>> sv/rkpu_pkg.sv
// Shared types, constants and tables of the pose update block.
// No dependencies.
package rkpu_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MODEL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_MIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_MAX  = 3'd5;

    localparam logic [15:0] TIME_STEP_RST = 16'd6554;
    localparam logic [14:0] SPEED_MAX_RST = 15'd2048;
    localparam logic [14:0] TURN_MAX_RST  = 15'd25736;

    // CORDIC start value (inverse gain) and rad to binary angle factor, Q.30 and Q.16
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [32:0] RAD_TO_BAM  = 33'sd683565276;

    localparam int unsigned CW_W  = 34;   // CORDIC datapath
    localparam int unsigned MUL_W = 33;   // shared multiplier operands

    typedef enum logic [4:0] {
        ST_IDLE, ST_SQA, ST_SQB, ST_SMIN, ST_SMAX, ST_CMP, ST_SQRT,
        ST_MX, ST_DX, ST_DXW, ST_MY, ST_DY, ST_DYW,
        ST_UPREP, ST_UCOR, ST_UMC, ST_UMS, ST_USAV,
        ST_DISPX, ST_DISPY, ST_DISPH, ST_HMUL, ST_HK, ST_HSAV, ST_FIN
    } state_t;

    function automatic logic signed [CW_W-1:0] atan_q31(input logic [4:0] i);
        logic signed [CW_W-1:0] v;
        case (i)
            5'd0:  v = 34'sd536870912;
            5'd1:  v = 34'sd316933406;
            5'd2:  v = 34'sd167458907;
            5'd3:  v = 34'sd85004756;
            5'd4:  v = 34'sd42667331;
            5'd5:  v = 34'sd21354465;
            5'd6:  v = 34'sd10679838;
            5'd7:  v = 34'sd5340245;
            5'd8:  v = 34'sd2670163;
            5'd9:  v = 34'sd1335087;
            5'd10: v = 34'sd667544;
            5'd11: v = 34'sd333772;
            5'd12: v = 34'sd166886;
            5'd13: v = 34'sd83443;
            5'd14: v = 34'sd41722;
            5'd15: v = 34'sd20861;
            5'd16: v = 34'sd10430;
            5'd17: v = 34'sd5215;
            5'd18: v = 34'sd2608;
            5'd19: v = 34'sd1304;
            5'd20: v = 34'sd652;
            5'd21: v = 34'sd326;
            5'd22: v = 34'sd163;
            5'd23: v = 34'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> sv/rkpu_mul.sv
// Shared signed multiplier with a registered product.
// Depends on rkpu_pkg.
module rkpu_mul
(
    input  logic                                  clk,
    input  logic signed [rkpu_pkg::MUL_W-1:0]     a,
    input  logic signed [rkpu_pkg::MUL_W-1:0]     b,
    output logic signed [2*rkpu_pkg::MUL_W-1:0]   p
);

    logic signed [2*rkpu_pkg::MUL_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

>>> sv/rkpu_sqdiv.sv
// Bit-serial square root and divide sharing one compare-subtract stage.
// Depends on nothing but its ports.
module rkpu_sqdiv
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        op_sqrt,
    input  logic [47:0] operand,   // sqrt: radicand; divide: dividend (< 2^42)
    input  logic [23:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [23:0] result
);

    logic [47:0] acc_reg, acc_next;
    logic [25:0] rem_reg, rem_next;
    logic [23:0] res_reg, res_next;
    logic [23:0] dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        sqrt_reg, sqrt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [25:0] rem_sh;
    logic [25:0] trial;
    logic        ge;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        res_reg  <= res_next;
        dvs_reg  <= dvs_next;
        cnt_reg  <= cnt_next;
        sqrt_reg <= sqrt_next;
    end

    always_comb
    begin
        if (sqrt_reg)
        begin
            rem_sh = {rem_reg[23:0], acc_reg[47:46]};
            trial  = {res_reg, 2'b01};
        end
        else
        begin
            rem_sh = {rem_reg[24:0], acc_reg[47]};
            trial  = {2'b00, dvs_reg};
        end
        ge = (rem_sh >= trial);

        acc_next  = acc_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        sqrt_next = sqrt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            busy_next = 1'b1;
            sqrt_next = op_sqrt;
            dvs_next  = divisor;
            res_next  = '0;
            if (op_sqrt)
            begin
                acc_next = operand;
                rem_next = '0;
                cnt_next = 5'd23;
            end
            else
            begin
                // quotient is known to fit 19 bits: preload the high part
                acc_next = {operand[18:0], 29'd0};
                rem_next = {3'd0, operand[41:19]};
                cnt_next = 5'd18;
            end
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (rem_sh - trial) : rem_sh;
            res_next = {res_reg[22:0], ge};
            acc_next = sqrt_reg ? {acc_reg[45:0], 2'b00} : {acc_reg[46:0], 1'b0};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = res_reg;

endmodule

>>> sv/rkpu_cordic.sv
// Rotation-mode CORDIC, one micro-rotation per cycle, for cos and sin of a heading.
// Depends on rkpu_pkg.
module rkpu_cordic
#(
    parameter int STEPS = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [15:0]                        angle,
    output logic                               busy,
    output logic                               done,
    output logic signed [rkpu_pkg::CW_W-1:0]   cos_q,
    output logic signed [rkpu_pkg::CW_W-1:0]   sin_q
);

    localparam int CNT_W = $clog2(STEPS);
    localparam int W     = rkpu_pkg::CW_W;

    logic signed [W-1:0] x_reg, x_next, y_reg, y_next, a_reg, a_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                neg_reg, neg_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic signed [W-1:0] a0;
    logic signed [W-1:0] xs, ys, at;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        a_reg   <= a_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        a0 = W'(signed'({angle, 16'd0}));
        xs = x_reg >>> cnt_reg;
        ys = y_reg >>> cnt_reg;
        at = rkpu_pkg::atan_q31(5'(cnt_reg));

        x_next    = x_reg;
        y_next    = y_reg;
        a_next    = a_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            x_next    = rkpu_pkg::CORDIC_GAIN;
            y_next    = '0;
            neg_next  = 1'b0;
            a_next    = a0;
            // fold the back half-plane onto the front one, negate at the end
            if (a0 > (W'(1) <<< 30))
            begin
                a_next   = a0 - (W'(1) <<< 31);
                neg_next = 1'b1;
            end
            else if (a0 < -(W'(1) <<< 30))
            begin
                a_next   = a0 + (W'(1) <<< 31);
                neg_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (!a_reg[W-1])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                a_next = a_reg - at;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                a_next = a_reg + at;
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign busy  = busy_reg;
    assign done  = done_reg;
    assign cos_q = neg_reg ? -x_reg : x_reg;
    assign sin_q = neg_reg ? -y_reg : y_reg;

endmodule

>>> sv/robot_kinematic_pose_update_top.sv
// Top level of the kinematic pose update: sequencer, pose state and ports.
// Depends on rkpu_pkg, rkpu_mul, rkpu_sqdiv, rkpu_cordic and the macros header.

// One velocity item advances the stored pose (x, y Q16.16, heading binary angle) by one
// Euler step and returns the new pose as one item. The block takes one item at a time:
// s_axis_tready is high only while the sequencer is idle. All products go through one
// registered multiplier. A holonomic step skips the pose update when the speed is below
// speed_min and, when the speed is limited, runs one 24-step square root and two
// 19-step divides on the shared bit-serial unit; a unicycle step waits on the CORDIC,
// which does one rotation per cycle. A finished pose waits in the output register
// while the next item is accepted. Configuration writes are always ready and take
// effect at once; write only while no item is in progress.
`include "robot_kinematic_pose_update_top_macros.svh"

module robot_kinematic_pose_update_top
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] vel_a, [31:16] vel_b
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [31:0] out_x, [63:32] out_y, [79:64] out_heading
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [rkpu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int MW = rkpu_pkg::MUL_W;

    rkpu_pkg::state_t state_reg, state_next;

    logic        model_reg;
    logic [15:0] dt_reg;
    logic [14:0] smin_reg, smax_reg, tmin_reg, tmax_reg;

    logic signed [15:0] va_reg, va_next, vb_reg, vb_next;
    logic [31:0]        sq_reg, sq_next;
    logic               below_reg, below_next;
    logic [23:0]        r_reg, r_next;
    logic signed [20:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [15:0] v_reg, v_next;
    logic signed [16:0] w_reg, w_next;
    logic signed [32:0] dh_reg, dh_next;
    logic signed [31:0] px_reg, px_next, py_reg, py_next;
    logic [15:0]        hd_reg, hd_next;
    logic [79:0]        out_reg, out_next;
    logic               ovld_reg, ovld_next;

    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [2*MW-1:0] prod;
    logic signed [2*MW-1:0] rnd16, rnd26, rnd44;

    logic        sd_start, sd_sqrt, sd_busy, sd_done;
    logic [47:0] sd_operand;
    logic [23:0] sd_result;

    logic                             cr_start, cr_busy, cr_done;
    logic signed [rkpu_pkg::CW_W-1:0] cr_cos, cr_sin;

    logic signed [16:0] va_abs, vb_abs;
    logic signed [16:0] w_lim;
    logic signed [15:0] v_lim;
    logic signed [32:0] pos_sum;

    rkpu_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    rkpu_sqdiv u_sqdiv
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sd_start),
        .op_sqrt (sd_sqrt),
        .operand (sd_operand),
        .divisor (r_reg),
        .busy    (sd_busy),
        .done    (sd_done),
        .result  (sd_result)
    );

    rkpu_cordic #(.STEPS(CORDIC_STEPS)) u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cr_start),
        .angle (hd_reg),
        .busy  (cr_busy),
        .done  (cr_done),
        .cos_q (cr_cos),
        .sin_q (cr_sin)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == rkpu_pkg::ST_IDLE);
    assign m_axis_tvalid = ovld_reg;
    assign m_axis_tdata  = out_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_reg <= 1'b0;
            dt_reg    <= rkpu_pkg::TIME_STEP_RST;
            smin_reg  <= '0;
            smax_reg  <= rkpu_pkg::SPEED_MAX_RST;
            tmin_reg  <= '0;
            tmax_reg  <= rkpu_pkg::TURN_MAX_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rkpu_pkg::REG_MODEL:     model_reg <= cfg_data[0];
                rkpu_pkg::REG_TIME_STEP: dt_reg    <= cfg_data;
                rkpu_pkg::REG_SPEED_MIN: smin_reg  <= cfg_data[14:0];
                rkpu_pkg::REG_SPEED_MAX: smax_reg  <= cfg_data[14:0];
                rkpu_pkg::REG_TURN_MIN:  tmin_reg  <= cfg_data[14:0];
                rkpu_pkg::REG_TURN_MAX:  tmax_reg  <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rkpu_pkg::ST_IDLE;
            px_reg    <= '0;
            py_reg    <= '0;
            hd_reg    <= '0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            px_reg    <= px_next;
            py_reg    <= py_next;
            hd_reg    <= hd_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        va_reg    <= va_next;
        vb_reg    <= vb_next;
        sq_reg    <= sq_next;
        below_reg <= below_next;
        r_reg     <= r_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        v_reg     <= v_next;
        w_reg     <= w_next;
        dh_reg    <= dh_next;
        out_reg   <= out_next;
    end

    always_comb
    begin
        va_abs = va_reg[15] ? -17'(va_reg) : 17'(va_reg);
        vb_abs = vb_reg[15] ? -17'(vb_reg) : 17'(vb_reg);
        rnd16  = (prod + (2*MW)'(1 << 15)) >>> 16;
        rnd26  = (prod + (2*MW)'(1 << 25)) >>> 26;
        rnd44  = (prod + ((2*MW)'(1) <<< 43)) >>> 44;
        pos_sum = '0;

        // unicycle limits: clamp first, then dead zone
        v_lim = (va_reg < $signed({1'b0, smax_reg})) ? va_reg : $signed({1'b0, smax_reg});
        w_lim = (vb_abs < $signed({2'b00, tmax_reg})) ? vb_abs : $signed({2'b00, tmax_reg});

        state_next = state_reg;
        va_next    = va_reg;
        vb_next    = vb_reg;
        sq_next    = sq_reg;
        below_next = below_reg;
        r_next     = r_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        v_next     = v_reg;
        w_next     = w_reg;
        dh_next    = dh_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        hd_next    = hd_reg;
        out_next   = out_reg;
        ovld_next  = ovld_reg && !m_axis_tready;
        mul_a      = '0;
        mul_b      = '0;
        sd_start   = 1'b0;
        sd_sqrt    = 1'b0;
        sd_operand = '0;
        cr_start   = 1'b0;

        case (state_reg)
            rkpu_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    va_next    = s_axis_tdata[15:0];
                    vb_next    = s_axis_tdata[31:16];
                    state_next = model_reg ? rkpu_pkg::ST_UPREP : rkpu_pkg::ST_SQA;
                end
            end
            rkpu_pkg::ST_SQA:
            begin
                mul_a      = MW'(va_reg);
                mul_b      = MW'(va_reg);
                state_next = rkpu_pkg::ST_SQB;
            end
            rkpu_pkg::ST_SQB:
            begin
                sq_next    = prod[31:0];
                mul_a      = MW'(vb_reg);
                mul_b      = MW'(vb_reg);
                state_next = rkpu_pkg::ST_SMIN;
            end
            rkpu_pkg::ST_SMIN:
            begin
                sq_next    = sq_reg + prod[31:0];
                mul_a      = MW'($signed({1'b0, smin_reg}));
                mul_b      = MW'($signed({1'b0, smin_reg}));
                state_next = rkpu_pkg::ST_SMAX;
            end
            rkpu_pkg::ST_SMAX:
            begin
                below_next = (sq_reg < prod[31:0]);
                mul_a      = MW'($signed({1'b0, smax_reg}));
                mul_b      = MW'($signed({1'b0, smax_reg}));
                state_next = rkpu_pkg::ST_CMP;
            end
            rkpu_pkg::ST_CMP:
            begin
                if (below_reg)
                begin
                    state_next = rkpu_pkg::ST_FIN;
                end
                else if (sq_reg > prod[31:0])
                begin
                    sd_start   = 1'b1;
                    sd_sqrt    = 1'b1;
                    sd_operand = {sq_reg, 16'd0};
                    state_next = rkpu_pkg::ST_SQRT;
                end
                else
                begin
                    cx_next    = 21'(va_reg) <<< 4;
                    cy_next    = 21'(vb_reg) <<< 4;
                    state_next = rkpu_pkg::ST_DISPX;
                end
            end
            rkpu_pkg::ST_SQRT:
            begin
                if (sd_done)
                begin
                    r_next     = sd_result;
                    state_next = rkpu_pkg::ST_MX;
                end
            end
            rkpu_pkg::ST_MX:
            begin
                mul_a      = MW'(va_abs);
                mul_b      = MW'($signed({1'b0, smax_reg}));
                state_next = rkpu_pkg::ST_DX;
            end
            rkpu_pkg::ST_DX:
            begin
                sd_start   = 1'b1;
                sd_operand = {6'd0, prod[29:0], 12'd0};
                state_next = rkpu_pkg::ST_DXW;
            end
            rkpu_pkg::ST_DXW:
            begin
                if (sd_done)
                begin
                    cx_next    = va_reg[15] ? -21'(sd_result[19:0]) : 21'(sd_result[19:0]);
                    state_next = rkpu_pkg::ST_MY;
                end
            end
            rkpu_pkg::ST_MY:
            begin
                mul_a      = MW'(vb_abs);
                mul_b      = MW'($signed({1'b0, smax_reg}));
                state_next = rkpu_pkg::ST_DY;
            end
            rkpu_pkg::ST_DY:
            begin
                sd_start   = 1'b1;
                sd_operand = {6'd0, prod[29:0], 12'd0};
                state_next = rkpu_pkg::ST_DYW;
            end
            rkpu_pkg::ST_DYW:
            begin
                if (sd_done)
                begin
                    cy_next    = vb_reg[15] ? -21'(sd_result[19:0]) : 21'(sd_result[19:0]);
                    state_next = rkpu_pkg::ST_DISPX;
                end
            end
            rkpu_pkg::ST_UPREP:
            begin
                v_next = (v_lim > $signed({1'b0, smin_reg})) ? v_lim : '0;
                if (w_lim > $signed({2'b00, tmin_reg}))
                begin
                    w_next = vb_reg[15] ? -w_lim : w_lim;
                end
                else
                begin
                    w_next = '0;
                end
                cr_start   = 1'b1;
                state_next = rkpu_pkg::ST_UCOR;
            end
            rkpu_pkg::ST_UCOR:
            begin
                if (cr_done)
                begin
                    state_next = rkpu_pkg::ST_UMC;
                end
            end
            rkpu_pkg::ST_UMC:
            begin
                mul_a      = MW'(v_reg);
                mul_b      = MW'(cr_cos);
                state_next = rkpu_pkg::ST_UMS;
            end
            rkpu_pkg::ST_UMS:
            begin
                cx_next    = rnd26[20:0];
                mul_a      = MW'(v_reg);
                mul_b      = MW'(cr_sin);
                state_next = rkpu_pkg::ST_USAV;
            end
            rkpu_pkg::ST_USAV:
            begin
                cy_next    = rnd26[20:0];
                state_next = rkpu_pkg::ST_DISPX;
            end
            rkpu_pkg::ST_DISPX:
            begin
                mul_a      = MW'(cx_reg);
                mul_b      = MW'($signed({1'b0, dt_reg}));
                state_next = rkpu_pkg::ST_DISPY;
            end
            rkpu_pkg::ST_DISPY:
            begin
                pos_sum = 33'(px_reg) + rnd16[32:0];
                if (pos_sum > 33'sh0_7FFF_FFFF)
                begin
                    px_next = 32'sh7FFF_FFFF;
                end
                else if (pos_sum < -33'sh0_8000_0000)
                begin
                    px_next = 32'sh8000_0000;
                end
                else
                begin
                    px_next = pos_sum[31:0];
                end
                mul_a      = MW'(cy_reg);
                mul_b      = MW'($signed({1'b0, dt_reg}));
                state_next = rkpu_pkg::ST_DISPH;
            end
            rkpu_pkg::ST_DISPH:
            begin
                pos_sum = 33'(py_reg) + rnd16[32:0];
                if (pos_sum > 33'sh0_7FFF_FFFF)
                begin
                    py_next = 32'sh7FFF_FFFF;
                end
                else if (pos_sum < -33'sh0_8000_0000)
                begin
                    py_next = 32'sh8000_0000;
                end
                else
                begin
                    py_next = pos_sum[31:0];
                end
                mul_a      = MW'(w_reg);
                mul_b      = MW'($signed({1'b0, dt_reg}));
                state_next = model_reg ? rkpu_pkg::ST_HMUL : rkpu_pkg::ST_FIN;
            end
            rkpu_pkg::ST_HMUL:
            begin
                dh_next    = prod[32:0];
                state_next = rkpu_pkg::ST_HK;
            end
            rkpu_pkg::ST_HK:
            begin
                mul_a      = dh_reg;
                mul_b      = rkpu_pkg::RAD_TO_BAM;
                state_next = rkpu_pkg::ST_HSAV;
            end
            rkpu_pkg::ST_HSAV:
            begin
                hd_next    = hd_reg + rnd44[15:0];
                state_next = rkpu_pkg::ST_FIN;
            end
            rkpu_pkg::ST_FIN:
            begin
                // hold until the output register is free
                if (!ovld_reg || m_axis_tready)
                begin
                    out_next   = {hd_reg, py_reg, px_reg};
                    ovld_next  = 1'b1;
                    state_next = rkpu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rkpu_pkg::ST_IDLE;
            end
        endcase
    end

    `RKPU_ASSERT_NEVER(a_units_exclusive, clk, rst_n, sd_busy && cr_busy)
    `RKPU_ASSERT_NEXT(a_one_item_at_a_time, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `RKPU_ASSERT_NEXT(a_hold_heading_integrator, clk, rst_n, !model_reg && state_reg != rkpu_pkg::ST_IDLE, hd_reg == $past(hd_reg))

endmodule
